/* rtl/core/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants, codes and controller/datapath interface types for the
// linear probing hash table core.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

    localparam int DEF_SLOTS       = 1024;
    localparam int DEF_KEY_WIDTH   = 64;
    localparam int DEF_VALUE_WIDTH = 64;

    localparam int FUNC_W     = 3;
    localparam int HASH_W     = 64;
    localparam int SLOT_OUT_W = 10;
    localparam int CAP_LOG2_W = 4;
    localparam int LIMIT_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int MARK_W     = 2;

    localparam logic [CAP_LOG2_W-1:0] CAP_LOG2_RST = 4'd10;
    localparam logic [LIMIT_W-1:0]    LOAD_LIMIT_RST = 11'd768;

    localparam logic [CFG_IDX_W-1:0] CFG_CAP_LOG2   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT = 2'd1;

    localparam logic [FUNC_W-1:0] FN_INSERT   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_READ     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_HAS_KEY  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_INDEX_OF = 3'd4;

    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

    typedef struct packed {
        logic clear;
        logic start;
        logic probe;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic probe_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/core/lpht_ram.sv */
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/lpht_ctrl.sv */
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller: mark clearing pass after reset, request accept, slot probe
// sequence and commit/result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lpht_pkg::t_sts i_sts,
    output lpht_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_FINISH
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    if (i_sts.clear_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_PROBE;
                    end
                end
                ST_PROBE: begin
                    if (i_sts.probe_done) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_cmd.clear  = (r_state == ST_CLEAR);
    assign o_cmd.start  = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.probe  = (r_state == ST_PROBE);
    assign o_cmd.finish = (r_state == ST_FINISH) && i_sts.out_free;

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.clear, o_cmd.start, o_cmd.probe, o_cmd.finish}))
        else $error("lpht_ctrl: more than one command active");

    a_probe_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> o_cmd.probe)
        else $error("lpht_ctrl: probe did not follow accept");

    a_finish_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.probe && i_sts.probe_done |=> (r_state == ST_FINISH))
        else $error("lpht_ctrl: probe end did not lead to commit");

endmodule

`default_nettype wire

/* rtl/core/lpht_dp.sv */
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: configuration registers, slot key/value/mark memories, probe
// registers, used-slot count, commit logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_dp #(
    parameter int SLOTS       = lpht_pkg::DEF_SLOTS,
    parameter int KEY_WIDTH   = lpht_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = lpht_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire lpht_pkg::t_cmd                  i_cmd,
    output lpht_pkg::t_sts                       o_sts,
    input  wire logic                            i_cfg_valid,
    input  wire logic [lpht_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lpht_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [lpht_pkg::FUNC_W-1:0]     i_func,
    input  wire logic [KEY_WIDTH-1:0]            i_key,
    input  wire logic [VALUE_WIDTH-1:0]          i_value,
    input  wire logic [lpht_pkg::HASH_W-1:0]     i_hash_value,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic                                 o_found,
    output logic [VALUE_WIDTH-1:0]               o_read_value,
    output logic [lpht_pkg::SLOT_OUT_W-1:0]      o_slot_index,
    output logic                                 o_status
);

    localparam int IDX_W      = $clog2(SLOTS);
    localparam int FLOOR_LOG2 = $clog2(SLOTS + 1) - 1;
    localparam int SO_W       = lpht_pkg::SLOT_OUT_W;
    localparam int LIM_W      = lpht_pkg::LIMIT_W;

    logic [lpht_pkg::CAP_LOG2_W-1:0] r_cap_log2;
    logic [LIM_W-1:0]                r_load_limit;
    logic [LIM_W-1:0]                r_used;
    logic [IDX_W-1:0]                r_clr_addr;

    logic [lpht_pkg::FUNC_W-1:0] r_func;
    logic [KEY_WIDTH-1:0]        r_key;
    logic [VALUE_WIDTH-1:0]      r_val;
    logic [IDX_W-1:0]            r_cur;
    logic [IDX_W-1:0]            r_n;
    logic                        r_hit;
    logic                        r_tomb;
    logic                        r_empty;
    logic [IDX_W-1:0]            r_hit_at;
    logic [IDX_W-1:0]            r_tomb_at;
    logic [IDX_W-1:0]            r_empty_at;
    logic [VALUE_WIDTH-1:0]      r_rdat;

    logic                   r_out_valid;
    logic                   r_out_found;
    logic [VALUE_WIDTH-1:0] r_out_rval;
    logic [SO_W-1:0]        r_out_slot;
    logic                   r_out_status;

    logic [4:0]                  cap_log2;
    logic [IDX_W-1:0]            mask;
    logic [IDX_W-1:0]            start_idx;
    logic [IDX_W-1:0]            next_idx;
    logic [IDX_W-1:0]            rd_addr;
    logic [KEY_WIDTH-1:0]        key_rdata;
    logic [VALUE_WIDTH-1:0]      val_rdata;
    logic [lpht_pkg::MARK_W-1:0] mark_rdata;
    logic                        is_used;
    logic                        is_tomb;
    logic                        stop_hit;
    logic                        stop_empty;
    logic                        probe_last;

    logic [IDX_W-1:0]            sel_slot;
    logic                        over_limit;
    logic                        c_found;
    logic                        c_status;
    logic                        c_slot_en;
    logic [VALUE_WIDTH-1:0]      c_rval;
    logic                        c_key_we;
    logic                        c_val_we;
    logic                        c_mark_we;
    logic [lpht_pkg::MARK_W-1:0] c_mark;
    logic                        c_inc;
    logic [IDX_W+SO_W-1:0]       slot_wide;

    logic                        mark_we;
    logic [IDX_W-1:0]            mark_waddr;
    logic [lpht_pkg::MARK_W-1:0] mark_wdata;

    always_comb begin
        cap_log2 = {1'b0, r_cap_log2};
        if (r_cap_log2 == '0) begin
            cap_log2 = 5'd1;
        end
        if (cap_log2 > 5'(FLOOR_LOG2)) begin
            cap_log2 = 5'(FLOOR_LOG2);
        end
    end

    assign mask       = ~({IDX_W{1'b1}} << cap_log2);
    assign start_idx  = i_hash_value[IDX_W-1:0] & mask;
    assign next_idx   = (r_cur + IDX_W'(1)) & mask;
    assign rd_addr    = i_cmd.start ? start_idx : next_idx;

    assign is_used    = (mark_rdata == lpht_pkg::MARK_USED);
    assign is_tomb    = (mark_rdata == lpht_pkg::MARK_TOMB);
    assign stop_hit   = is_used && (key_rdata == r_key);
    assign stop_empty = !is_used && !is_tomb;
    assign probe_last = (r_n == mask);

    assign o_sts.probe_done = stop_hit || stop_empty || probe_last;
    assign o_sts.clear_last = (r_clr_addr == IDX_W'(SLOTS - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_log2   <= lpht_pkg::CAP_LOG2_RST;
            r_load_limit <= lpht_pkg::LOAD_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lpht_pkg::CFG_CAP_LOG2: begin
                    r_cap_log2 <= i_cfg_data[lpht_pkg::CAP_LOG2_W-1:0];
                end
                lpht_pkg::CFG_LOAD_LIMIT: begin
                    r_load_limit <= i_cfg_data[LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear && !o_sts.clear_last) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_val   <= i_value;
            r_cur   <= start_idx;
            r_n     <= '0;
            r_hit   <= 1'b0;
            r_tomb  <= 1'b0;
            r_empty <= 1'b0;
        end else if (i_cmd.probe) begin
            r_cur <= next_idx;
            r_n   <= r_n + IDX_W'(1);
            if (is_tomb && !r_tomb) begin
                r_tomb    <= 1'b1;
                r_tomb_at <= r_cur;
            end
            if (stop_hit) begin
                r_hit    <= 1'b1;
                r_hit_at <= r_cur;
                r_rdat   <= val_rdata;
            end
            if (stop_empty) begin
                r_empty    <= 1'b1;
                r_empty_at <= r_cur;
            end
        end
    end

    assign over_limit = ({1'b0, r_used} + (LIM_W + 1)'(1)) > {1'b0, r_load_limit};

    always_comb begin
        if (r_hit) begin
            sel_slot = r_hit_at;
        end else if (r_tomb) begin
            sel_slot = r_tomb_at;
        end else if (r_empty) begin
            sel_slot = r_empty_at;
        end else begin
            sel_slot = '0;
        end
    end

    always_comb begin
        c_found   = r_hit;
        c_status  = !(r_hit || r_tomb || r_empty);
        c_slot_en = 1'b1;
        c_rval    = '0;
        c_key_we  = 1'b0;
        c_val_we  = 1'b0;
        c_mark_we = 1'b0;
        c_mark    = lpht_pkg::MARK_USED;
        c_inc     = 1'b0;
        case (r_func)
            lpht_pkg::FN_INSERT: begin
                if (r_hit) begin
                    c_val_we = 1'b1;
                end else if (r_tomb) begin
                    c_key_we  = 1'b1;
                    c_val_we  = 1'b1;
                    c_mark_we = 1'b1;
                end else if (r_empty) begin
                    if (over_limit) begin
                        c_status = 1'b1;
                    end else begin
                        c_key_we  = 1'b1;
                        c_val_we  = 1'b1;
                        c_mark_we = 1'b1;
                        c_inc     = 1'b1;
                    end
                end
            end
            lpht_pkg::FN_REMOVE: begin
                if (r_hit) begin
                    c_mark_we = 1'b1;
                    c_mark    = lpht_pkg::MARK_TOMB;
                end
            end
            lpht_pkg::FN_READ: begin
                if (r_hit) begin
                    c_rval = r_rdat;
                end
            end
            lpht_pkg::FN_HAS_KEY, lpht_pkg::FN_INDEX_OF: begin
            end
            default: begin
                c_found   = 1'b0;
                c_status  = 1'b0;
                c_slot_en = 1'b0;
            end
        endcase
    end

    assign slot_wide = {SO_W'(0), (c_slot_en ? sel_slot : IDX_W'(0))};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.finish && c_inc) begin
            r_used <= r_used + LIM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_found  <= c_found;
            r_out_rval   <= c_rval;
            r_out_slot   <= slot_wide[SO_W-1:0];
            r_out_status <= c_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_out_found;
    assign o_read_value = r_out_rval;
    assign o_slot_index = r_out_slot;
    assign o_status     = r_out_status;

    assign mark_we    = i_cmd.clear || (i_cmd.finish && c_mark_we);
    assign mark_waddr = i_cmd.clear ? r_clr_addr : sel_slot;
    assign mark_wdata = i_cmd.clear ? lpht_pkg::MARK_EMPTY : c_mark;

    lpht_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (SLOTS)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish && c_key_we),
        .i_waddr (sel_slot),
        .i_wdata (r_key),
        .i_raddr (rd_addr),
        .o_rdata (key_rdata)
    );

    lpht_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (SLOTS)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish && c_val_we),
        .i_waddr (sel_slot),
        .i_wdata (r_val),
        .i_raddr (rd_addr),
        .o_rdata (val_rdata)
    );

    lpht_ram #(
        .WIDTH (lpht_pkg::MARK_W),
        .DEPTH (SLOTS)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (rd_addr),
        .o_rdata (mark_rdata)
    );

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != $past(r_used)) |-> (r_used == $past(r_used) + LIM_W'(1)))
        else $error("lpht_dp: used count moved by other than one");

    a_key_with_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && c_key_we) |-> (mark_we && mark_wdata == lpht_pkg::MARK_USED))
        else $error("lpht_dp: key stored without used mark");

    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> !r_out_found)
        else $error("lpht_dp: full status with a hit");

    a_no_store_on_miss_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !r_hit && r_func != lpht_pkg::FN_INSERT) |-> !mark_we)
        else $error("lpht_dp: slot changed without hit");

endmodule

`default_nettype wire

/* rtl/core/linear_probe_hash_table_core.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing hash table with linear probing and tombstones.
//
// Request channel (i_in_valid/o_in_ready) carries func, key, value and a
// precomputed hash; the result channel (o_out_valid/i_out_ready) returns
// found, read_value, slot_index and status, one result per request.
// Configuration writes (i_cfg_valid/o_cfg_ready) set capacity_log2 (index 0)
// and load_limit (index 1); they are taken every cycle and belong between
// transactions.
// After reset the slot marks are swept to empty, one slot per cycle, so the
// request channel stays closed until every slot is swept.
// A request passes through accept, a probe step for each slot read from
// the key/value/mark memories (1 up to the active capacity), and commit.
// The next request is accepted the cycle after commit.
// A finished result is held in an output register; a new request is taken
// while it waits, and its commit waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table_core #(
    parameter int SLOTS       = lpht_pkg::DEF_SLOTS,
    parameter int KEY_WIDTH   = lpht_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = lpht_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [lpht_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lpht_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [lpht_pkg::FUNC_W-1:0]     i_func,
    input  wire logic [KEY_WIDTH-1:0]            i_key,
    input  wire logic [VALUE_WIDTH-1:0]          i_value,
    input  wire logic [lpht_pkg::HASH_W-1:0]     i_hash_value,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_found,
    output logic [VALUE_WIDTH-1:0]               o_read_value,
    output logic [lpht_pkg::SLOT_OUT_W-1:0]      o_slot_index,
    output logic                                 o_status
);

    lpht_pkg::t_cmd cmd;
    lpht_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lpht_dp #(
        .SLOTS       (SLOTS),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_func),
        .i_key        (i_key),
        .i_value      (i_value),
        .i_hash_value (i_hash_value),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_found      (o_found),
        .o_read_value (o_read_value),
        .o_slot_index (o_slot_index),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire
